// ===== design/servo_pick_place_ramp_sequencer_unit_assert.svh =====
// Assertion macros for the pick-and-place ramp sequencer.
`ifndef SERVO_PICK_PLACE_RAMP_SEQUENCER_UNIT_ASSERT_SVH
`define SERVO_PICK_PLACE_RAMP_SEQUENCER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SPPRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define SPPRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SPPRS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SPPRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/spprs_pkg.sv =====
// Shared types, constants and arithmetic helpers for the ramp sequencer.
package spprs_pkg;

	localparam int NUM_CH   = 6;
	localparam int NUM_ARM  = 4;
	localparam int NUM_CFG  = 8;
	localparam int CFG_IDX_W = 8;
	localparam int ANGLE_W  = 12;
	localparam int DUTY_W   = 16;

	// Channel positions
	localparam int CH_BASE = 0;
	localparam int CH_J4   = 4;
	localparam int CH_GRIP = 5;

	// Register indexes
	localparam int CFG_START_BASE  = 0;
	localparam int CFG_TARGET_BASE = 4;

	// Duties in 1/16 us
	localparam logic [DUTY_W-1:0] DUTY_90     = 16'd24000;
	localparam logic [DUTY_W-1:0] DUTY_60     = 16'd18667;
	localparam logic [DUTY_W-1:0] DUTY_GRIP0  = 16'd18672;
	localparam logic [DUTY_W-1:0] DUTY_OFFSET = 16'd8000;
	localparam logic [DUTY_W-1:0] STEP_ARM    = 16'd160;
	localparam logic [DUTY_W-1:0] STEP_GRIP   = 16'd1440;

	// ceil(2^22 / 9): exact quotient for numerators below 2^21
	localparam logic [18:0] RECIP_9 = 19'd466034;
	localparam int RECIP_SHIFT = 22;

	typedef logic [DUTY_W-1:0] duty_t;
	typedef logic [NUM_CH-1:0][DUTY_W-1:0] duty_vec_t;
	typedef logic [NUM_CFG-1:0][DUTY_W-1:0] cfg_vec_t;

	typedef enum logic [2:0] {
		PH_PICK  = 3'd0,
		PH_LIFT1 = 3'd1,
		PH_PLACE = 3'd2,
		PH_LIFT2 = 3'd3,
		PH_DONE  = 3'd4
	} phase_t;

	typedef struct packed {
		duty_vec_t duty;
		phase_t    phase;
	} seq_state_t;

	// round(a * 100 / 9) + 8000, division by reciprocal multiply
	function automatic duty_t angle_to_duty(input logic [ANGLE_W-1:0] a);
		logic [18:0] num;
		logic [37:0] prod;
		num  = ({7'd0, a} << 6) + ({7'd0, a} << 5) + ({7'd0, a} << 2) + 19'd4;
		prod = {19'd0, num} * {19'd0, RECIP_9};
		return prod[RECIP_SHIFT +: DUTY_W] + DUTY_OFFSET;
	endfunction

	// One step toward target, snapping when closer than a step
	function automatic duty_t ramp(input duty_t cur, input duty_t tgt, input duty_t step);
		duty_t res;
		if (cur > tgt) begin
			res = ((cur - tgt) < step) ? tgt : cur - step;
		end else begin
			res = ((tgt - cur) < step) ? tgt : cur + step;
		end
		return res;
	endfunction

	// Ramp the selected groups
	function automatic duty_vec_t ramp_grp(input duty_vec_t d, input duty_vec_t t,
			input logic base, input logic arm, input logic grip);
		duty_vec_t r;
		r = d;
		if (base) begin
			r[CH_BASE] = ramp(d[CH_BASE], t[CH_BASE], STEP_ARM);
		end
		if (arm) begin
			for (int k = 1; k <= NUM_ARM; k++) begin
				r[k] = ramp(d[k], t[k], STEP_ARM);
			end
		end
		if (grip) begin
			r[CH_GRIP] = ramp(d[CH_GRIP], t[CH_GRIP], STEP_GRIP);
		end
		return r;
	endfunction

	// Joints 1..4 all on target
	function automatic logic arm_on(input duty_vec_t d, input duty_vec_t t);
		logic on;
		on = 1'b1;
		for (int k = 1; k <= NUM_ARM; k++) begin
			if (d[k] != t[k]) begin
				on = 1'b0;
			end
		end
		return on;
	endfunction

endpackage

// ===== design/spprs_cfg.sv =====
// Configuration register file; angles are stored already converted to duty.
module spprs_cfg
	import spprs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [ANGLE_W-1:0]   wr_angle,
	output cfg_vec_t             cfg_duty
);

	cfg_vec_t duty_q;
	duty_t    wr_duty;

	// angle to pulse width for the incoming write
	assign wr_duty = angle_to_duty(wr_angle);

	// register file, out-of-range indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) begin
				duty_q[i] <= DUTY_90;
			end
		end else begin
			for (int i = 0; i < NUM_CFG; i++) begin
				if (wr_en && (wr_index == CFG_IDX_W'(i))) begin
					duty_q[i] <= wr_duty;
				end
			end
		end
	end

	assign cfg_duty = duty_q;

endmodule

// ===== design/spprs_step.sv =====
// One control period: target selection, grouped ramps and phase advance.
module spprs_step
	import spprs_pkg::*;
(
	input  logic       tick,
	input  cfg_vec_t   cfg_duty,
	input  seq_state_t cur,
	output seq_state_t nxt
);

	duty_vec_t tgt;
	duty_vec_t d;
	phase_t    ph;
	phase_t    ph_inc;
	logic      base_first;

	// targets for the current phase
	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			tgt[k] = DUTY_90;
		end
		unique case (cur.phase)
			PH_PICK: begin
				for (int k = 0; k < NUM_ARM; k++) begin
					tgt[k] = cfg_duty[CFG_START_BASE + k];
				end
			end
			PH_LIFT1: begin
				tgt[CH_BASE] = cfg_duty[CFG_START_BASE];
			end
			PH_PLACE: begin
				for (int k = 0; k < NUM_ARM; k++) begin
					tgt[k] = cfg_duty[CFG_TARGET_BASE + k];
				end
				tgt[CH_GRIP] = DUTY_60;
			end
			PH_LIFT2: begin
				tgt[CH_GRIP] = DUTY_60;
			end
			default: begin
				tgt[CH_GRIP] = DUTY_90;
			end
		endcase
	end

	assign base_first = (cur.phase == PH_PICK) || (cur.phase == PH_PLACE);
	assign ph_inc     = phase_t'(cur.phase + 3'd1);

	// two move passes; the second only once the leading group has settled
	always_comb begin
		d  = cur.duty;
		ph = cur.phase;
		if (tick && (cur.phase < PH_DONE)) begin
			d = ramp_grp(d, tgt, base_first, !base_first, 1'b0);
			if (arm_on(d, tgt) && (d[CH_BASE] == tgt[CH_BASE])) begin
				d = ramp_grp(d, tgt, 1'b1, 1'b1, 1'b1);
				if (d[CH_GRIP] == tgt[CH_GRIP]) begin
					ph = ph_inc;
				end
			end
			if (base_first ? (d[CH_BASE] == tgt[CH_BASE]) : arm_on(d, tgt)) begin
				d = ramp_grp(d, tgt, 1'b1, 1'b1, 1'b0);
				if (arm_on(d, tgt) && (d[CH_BASE] == tgt[CH_BASE])) begin
					d = ramp_grp(d, tgt, 1'b1, 1'b1, 1'b1);
					if (d[CH_GRIP] == tgt[CH_GRIP]) begin
						ph = ph_inc;
					end
				end
			end
		end
		nxt.duty  = d;
		nxt.phase = ph;
	end

endmodule

// ===== design/servo_pick_place_ramp_sequencer_unit.sv =====
// Top level of the six-channel pick-and-place ramp sequencer.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | tick
//  out     | out_valid / out_ready| duty_base..duty_gripper, phase_now
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request per cycle while in_ready is high; each result is valid in the
// next cycle. The state register doubles as the result register, so in_ready
// is high whenever the result slot is empty or being taken this cycle.
// Reset: duties 24000 (gripper 18672), phase pick, angle registers 90 deg.
// cfg_ready is always high; index 8 and up is ignored.
`include "servo_pick_place_ramp_sequencer_unit_assert.svh"
module servo_pick_place_ramp_sequencer_unit
	import spprs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 tick,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DUTY_W-1:0]    duty_base,
	output logic [DUTY_W-1:0]    duty_joint1,
	output logic [DUTY_W-1:0]    duty_joint2,
	output logic [DUTY_W-1:0]    duty_joint3,
	output logic [DUTY_W-1:0]    duty_joint4,
	output logic [DUTY_W-1:0]    duty_gripper,
	output logic [2:0]           phase_now,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ANGLE_W-1:0]   cfg_data
);

	cfg_vec_t   cfg_duty;
	seq_state_t state_q;
	seq_state_t state_nxt;
	logic       out_valid_q;
	logic       in_acc;
	logic       phase_step_ok;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;

	spprs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_angle (cfg_data),
		.cfg_duty (cfg_duty)
	);

	spprs_step u_step (
		.tick     (tick),
		.cfg_duty (cfg_duty),
		.cur      (state_q),
		.nxt      (state_nxt)
	);

	// sequencer state, also the held result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CH; k++) begin
				state_q.duty[k] <= (k == CH_GRIP) ? DUTY_GRIP0 : DUTY_90;
			end
			state_q.phase <= PH_PICK;
		end else if (in_acc) begin
			state_q <= state_nxt;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign duty_base    = state_q.duty[CH_BASE];
	assign duty_joint1  = state_q.duty[1];
	assign duty_joint2  = state_q.duty[2];
	assign duty_joint3  = state_q.duty[3];
	assign duty_joint4  = state_q.duty[CH_J4];
	assign duty_gripper = state_q.duty[CH_GRIP];
	assign phase_now    = state_q.phase;

	// phase either holds or moves up by one per request
	assign phase_step_ok = (state_nxt.phase == state_q.phase) ||
		(state_nxt.phase == phase_t'(state_q.phase + 3'd1));

	// checks
	`SPPRS_ASSERT_NOW(a_phase_range, clk, arst_n, 1'b1, state_q.phase <= PH_DONE)
	`SPPRS_ASSERT_NOW(a_phase_step, clk, arst_n, in_acc, phase_step_ok)
	`SPPRS_ASSERT_NEXT(a_idle_tick, clk, arst_n, in_acc && !tick, state_q == $past(state_q))
	`SPPRS_ASSERT_NEXT(a_no_accept_hold, clk, arst_n, !in_acc, state_q == $past(state_q))

endmodule

// ===== dv/servo_pick_place_ramp_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the six-channel pick-and-place ramp sequencer.
module servo_pick_place_ramp_sequencer_unit_tb;
	import spprs_pkg::*;

	localparam int CLK_HALF      = 2;
	localparam int RESET_CYCLES  = 10;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_TICKS  = 850;
	localparam int DONE_GUARD    = 4000;
	localparam int LIMIT_NS      = 2_000_000;

	localparam int NUM_CHAN = 6;
	localparam int NUM_REGS = 8;
	localparam int CH_B     = 0;
	localparam int CH_G     = 5;
	localparam int REG_START0  = 0;
	localparam int REG_TARGET0 = 4;

	localparam logic [ANGLE_W-1:0] ANG_90  = 12'd1440;
	localparam logic [ANGLE_W-1:0] ANG_60  = 12'd960;
	localparam logic [ANGLE_W-1:0] ANG_MAX = 12'd2880;
	localparam logic [ANGLE_W-1:0] ANG_TOP = 12'hFFF;
	localparam logic [DUTY_W-1:0]  ARM_STRIDE  = 16'd160;
	localparam logic [DUTY_W-1:0]  GRIP_STRIDE = 16'd1440;

	typedef struct {
		duty_vec_t duty;
		phase_t    ph;
	} servo_report_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 tick;
	logic                 out_valid;
	logic                 out_ready;
	logic [DUTY_W-1:0]    duty_base;
	logic [DUTY_W-1:0]    duty_joint1;
	logic [DUTY_W-1:0]    duty_joint2;
	logic [DUTY_W-1:0]    duty_joint3;
	logic [DUTY_W-1:0]    duty_joint4;
	logic [DUTY_W-1:0]    duty_gripper;
	logic [2:0]           phase_now;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ANGLE_W-1:0]   cfg_data;

	// Predicted sequencer state
	duty_vec_t          model_duty;
	phase_t             model_phase;
	logic [ANGLE_W-1:0] model_angle [NUM_REGS];

	servo_report_t report_q[$];
	int            errors;
	bit            idle_on;
	bit            hold_req;

	string chan_name [NUM_CHAN] = '{"duty_base", "duty_joint1", "duty_joint2",
		"duty_joint3", "duty_joint4", "duty_gripper"};

	servo_pick_place_ramp_sequencer_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.tick         (tick),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.duty_base    (duty_base),
		.duty_joint1  (duty_joint1),
		.duty_joint2  (duty_joint2),
		.duty_joint3  (duty_joint3),
		.duty_joint4  (duty_joint4),
		.duty_gripper (duty_gripper),
		.phase_now    (phase_now),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("== FAIL ==");
		$finish;
	end

	// ---------------- predictor ----------------

	// angle in 1/16 deg -> pulse width in 1/16 us, rounded to nearest
	function automatic duty_t pulse_of_angle(input logic [ANGLE_W-1:0] a);
		int unsigned num;
		num = 32'(a) * 100 + 4;
		return duty_t'(num / 9 + 8000);
	endfunction

	function automatic duty_t step_toward(input duty_t cur, input duty_t goal,
			input duty_t stride);
		if (cur > goal) begin
			return (cur - goal < stride) ? goal : duty_t'(cur - stride);
		end
		return (goal - cur < stride) ? goal : duty_t'(cur + stride);
	endfunction

	function automatic void move_groups(input duty_vec_t goal, input bit base,
			input bit arm, input bit grip);
		if (base) begin
			model_duty[CH_B] = step_toward(model_duty[CH_B], goal[CH_B], ARM_STRIDE);
		end
		if (arm) begin
			for (int k = 1; k < CH_G; k++) begin
				model_duty[k] = step_toward(model_duty[k], goal[k], ARM_STRIDE);
			end
		end
		if (grip) begin
			model_duty[CH_G] = step_toward(model_duty[CH_G], goal[CH_G], GRIP_STRIDE);
		end
	endfunction

	function automatic bit arm_settled(input duty_vec_t goal);
		for (int k = 1; k < CH_G; k++) begin
			if (model_duty[k] != goal[k]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// one ramp of the leading group, then the whole set once base and arm land
	function automatic void sweep_pass(input duty_vec_t goal, input bit base,
			input bit arm, input phase_t nxt);
		move_groups(goal, base, arm, 1'b0);
		if (arm_settled(goal) && model_duty[CH_B] == goal[CH_B]) begin
			move_groups(goal, 1'b1, 1'b1, 1'b1);
			if (model_duty[CH_G] == goal[CH_G]) begin
				model_phase = nxt;
			end
		end
	endfunction

	function automatic void apply_tick(input logic t);
		logic [ANGLE_W-1:0] ang [NUM_CHAN];
		duty_vec_t goal;
		phase_t nxt;
		if (t && model_phase < PH_DONE) begin
			for (int k = 0; k < NUM_CHAN; k++) begin
				ang[k] = ANG_90;
			end
			case (model_phase)
				PH_PICK: begin
					for (int k = 0; k < 4; k++) begin
						ang[k] = model_angle[REG_START0 + k];
					end
				end
				PH_LIFT1: begin
					ang[CH_B] = model_angle[REG_START0];
				end
				PH_PLACE: begin
					for (int k = 0; k < 4; k++) begin
						ang[k] = model_angle[REG_TARGET0 + k];
					end
					ang[CH_G] = ANG_60;
				end
				default: begin
					ang[CH_G] = ANG_60;
				end
			endcase
			for (int k = 0; k < NUM_CHAN; k++) begin
				goal[k] = pulse_of_angle(ang[k]);
			end
			nxt = phase_t'(model_phase + 3'd1);
			// pick/place lead with the base, lifts lead with the arm
			if (model_phase == PH_PICK || model_phase == PH_PLACE) begin
				sweep_pass(goal, 1'b1, 1'b0, nxt);
				if (model_duty[CH_B] == goal[CH_B]) begin
					sweep_pass(goal, 1'b1, 1'b1, nxt);
				end
			end else begin
				sweep_pass(goal, 1'b0, 1'b1, nxt);
				if (arm_settled(goal)) begin
					sweep_pass(goal, 1'b1, 1'b1, nxt);
				end
			end
		end
	endfunction

	// ---------------- result checker ----------------

	always @(posedge clk) begin : check_results
		servo_report_t want;
		duty_vec_t     seen;
		if (arst_n && out_valid && out_ready) begin
			seen[0] = duty_base;
			seen[1] = duty_joint1;
			seen[2] = duty_joint2;
			seen[3] = duty_joint3;
			seen[4] = duty_joint4;
			seen[5] = duty_gripper;
			if (report_q.size() == 0) begin
				$error("result with no pending request: phase_now=%0d", phase_now);
				errors++;
			end else begin
				want = report_q.pop_front();
				for (int k = 0; k < NUM_CHAN; k++) begin
					if (seen[k] !== want.duty[k]) begin
						$error("%s: expected %0d, got %0d", chan_name[k], want.duty[k], seen[k]);
						errors++;
					end
				end
				if (phase_now !== want.ph) begin
					$error("phase_now: expected %0d, got %0d", want.ph, phase_now);
					errors++;
				end
			end
		end
	end

	// ---------------- result sink ----------------

	// random stall bursts, plus one long hold-off on request
	initial begin : sink_ready
		int stall_cnt;
		stall_cnt = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_cnt = HOLD_CYCLES;
			end else if (stall_cnt == 0 && idle_on && $urandom_range(0, 9) == 0) begin
				stall_cnt = $urandom_range(1, 16);
			end
			if (stall_cnt > 0) begin
				out_ready <= 1'b0;
				stall_cnt--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ---------------- shared drivers ----------------

	task automatic send_tick(input logic t);
		servo_report_t want;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		in_valid <= 1'b1;
		tick <= t;
		do @(posedge clk); while (!in_ready);
		apply_tick(t);
		want.duty = model_duty;
		want.ph = model_phase;
		report_q.push_back(want);
	endtask

	// drop the request line and let every pending result come back
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (report_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ANGLE_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx < NUM_REGS) begin
			model_angle[idx] = val;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [ANGLE_W-1:0] pick_angle();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return ANG_MAX;
			2: return ANG_TOP;
			default: return ANGLE_W'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic logic [CFG_IDX_W-1:0] pick_index();
		if ($urandom_range(0, 9) == 0) begin
			return CFG_IDX_W'($urandom_range(NUM_REGS, 255));
		end
		return CFG_IDX_W'($urandom_range(0, NUM_REGS - 1));
	endfunction

	// ---------------- tests ----------------

	// reset report, ignored indexes, angle extremes and over-range angles
	task automatic test_directed_extremes();
		idle_on = 1'b1;
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		wait_idle();
		write_reg(8'd8, ANG_TOP);
		write_reg(8'd255, ANG_TOP);
		for (int k = 0; k < 4; k++) begin
			write_reg(CFG_IDX_W'(REG_START0 + k), '0);
		end
		write_reg(CFG_IDX_W'(REG_TARGET0 + 0), ANG_TOP);
		write_reg(CFG_IDX_W'(REG_TARGET0 + 1), ANG_MAX);
		write_reg(CFG_IDX_W'(REG_TARGET0 + 2), '0);
		write_reg(CFG_IDX_W'(REG_TARGET0 + 3), ANG_TOP);
		repeat (6) send_tick(1'b1);
		send_tick(1'b0);
		wait_idle();
		write_reg(CFG_IDX_W'(REG_START0), ANG_MAX);
		write_reg(CFG_IDX_W'(REG_START0 + 1), ANG_TOP);
		write_reg(CFG_IDX_W'(REG_START0 + 3), ANG_60);
		repeat (6) send_tick(1'b1);
		send_tick(1'b0);
		wait_idle();
	endtask

	// long output hold-off while requests keep coming
	task automatic test_output_backpressure();
		idle_on = 1'b0;
		hold_req = 1'b1;
		for (int n = 0; n < 30; n++) begin
			send_tick(n % 5 != 0);
		end
		wait_idle();
	endtask

	// random ticks, with register rewrites between bursts
	task automatic test_random_sequencing();
		int until_cfg;
		until_cfg = $urandom_range(40, 90);
		idle_on = 1'b1;
		for (int n = 0; n < RANDOM_TICKS; n++) begin
			if (until_cfg == 0) begin
				wait_idle();
				repeat ($urandom_range(1, 3)) write_reg(pick_index(), pick_angle());
				idle_on = ($urandom_range(0, 3) != 0);
				until_cfg = $urandom_range(40, 90);
			end
			send_tick($urandom_range(0, 3) != 0);
			until_cfg--;
		end
		wait_idle();
	endtask

	// finish the sequence and confirm the done phase holds still
	task automatic test_run_to_done();
		int guard;
		guard = 0;
		idle_on = 1'b0;
		for (int k = 0; k < NUM_REGS; k++) begin
			write_reg(CFG_IDX_W'(k), ANG_90);
		end
		while (model_phase != PH_DONE && guard < DONE_GUARD) begin
			send_tick(1'b1);
			guard++;
		end
		repeat (6) send_tick($urandom_range(0, 1) != 0);
		send_tick(1'b1);
		send_tick(1'b0);
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		tick = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		idle_on = 1'b0;
		hold_req = 1'b0;
		for (int k = 0; k < NUM_CHAN; k++) begin
			model_duty[k] = 16'd24000;
		end
		model_duty[CH_G] = 16'd18672;
		model_phase = PH_PICK;
		for (int k = 0; k < NUM_REGS; k++) begin
			model_angle[k] = ANG_90;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_extremes();
		test_output_backpressure();
		test_random_sequencing();
		test_run_to_done();

		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/spprs_pkg.sv
design/spprs_cfg.sv
design/spprs_step.sv
design/servo_pick_place_ramp_sequencer_unit.sv
dv/servo_pick_place_ramp_sequencer_unit_tb.sv
